[hdl/gbc_pkg.sv]
package gbc_pkg;

    localparam int MAX_VERTICES = 256;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CHECK  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] edge_a;
        logic [7:0] edge_b;
    } gbc_in_t;

    typedef struct packed {
        logic biconnected;
        logic has_articulation;
        logic all_reached;
        logic edges_dropped;
    } gbc_out_t;

    // controller to datapath
    typedef struct packed {
        logic start_add;
        logic start_check;
        logic start_clear;
    } gbc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
    } gbc_stat_t;

endpackage

[hdl/graph_biconnectivity_check.sv]
// Biconnectivity checker. Edge words (kind 0) store two half edges in per-vertex
// adjacency lists; clear words (kind 2) sweep the 256 list heads, as does the pass
// right after reset, during which no word is accepted. A check word (kind 3
// ignored) runs a depth-first search from vertex 0 over single-port memories:
// an init pass over the vertex entries, a step sequence per half edge, whether
// back, skipped or tree edge, and per vertex pop, then a scan over the vertices,
// before the single result word is offered. One word is in work at a time, and
// the vertex count is written only while the block is idle.
module graph_biconnectivity_check import gbc_pkg::*; #(
    parameter int MAX_EDGES    = 1024
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  gbc_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output gbc_out_t   m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data
);

    logic [8:0] vcount_reg;
    gbc_cmd_t   cmd;
    gbc_stat_t  stat;
    logic       idle;

    assign cfg_ready = idle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= 9'd1;
        end else if (cfg_valid && cfg_ready) begin
            vcount_reg <= cfg_data;
        end
    end

    gbc_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready), .in_item(s_data),
        .out_valid(m_valid), .out_ready(m_ready),
        .stat, .cmd, .idle
    );

    gbc_datapath #(.MAX_EDGES(MAX_EDGES)) u_dp (
        .aclk, .aresetn, .cmd, .item(s_data),
        .vertex_count(vcount_reg), .stat, .result(m_data)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start_add || cmd.start_check || cmd.start_clear) |-> idle)
        else $error("command while busy");

endmodule

[hdl/gbc_datapath.sv]
module gbc_datapath import gbc_pkg::*; #(
    parameter int MAX_EDGES    = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  gbc_cmd_t  cmd,
    input  gbc_in_t   item,
    input  logic [8:0] vertex_count,
    output gbc_stat_t stat,
    output gbc_out_t  result
);

    localparam int VW = (MAX_VERTICES > 256) ? $clog2(MAX_VERTICES) : 8;
    localparam int VI = $clog2(MAX_VERTICES);
    localparam int HALF = 2 * MAX_EDGES;
    localparam int HI = $clog2(HALF);
    localparam int LW = HI + 1;                    // link index plus none bit
    localparam int CW = $clog2(HALF + 1);
    localparam int TW = $clog2(MAX_VERTICES + 1);
    localparam int DW = $clog2(MAX_VERTICES + 1);
    localparam logic [LW-1:0] LNONE = {LW{1'b1}};

    // datapath step codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_ADD1  = 4'd2;
    localparam logic [3:0] S_ADD2  = 4'd3;
    localparam logic [3:0] S_INIT  = 4'd4;
    localparam logic [3:0] S_DISC  = 4'd5;
    localparam logic [3:0] S_TOP   = 4'd6;
    localparam logic [3:0] S_LINK  = 4'd7;
    localparam logic [3:0] S_TGT   = 4'd8;
    localparam logic [3:0] S_POP   = 4'd9;
    localparam logic [3:0] S_POP2  = 4'd10;
    localparam logic [3:0] S_SCAN  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;
    localparam logic [3:0] S_RD    = 4'd13;
    localparam logic [3:0] S_BACK  = 4'd14;

    logic [3:0] st_reg;

    // memories
    logic [LW-1:0] head_mem [MAX_VERTICES];
    logic [LW-1:0] next_mem [HALF];
    logic [VW-1:0] tgt_mem  [HALF];
    logic [VI:0]   par_mem  [MAX_VERTICES];     // top bit marks none
    logic [TW-1:0] disc_mem [MAX_VERTICES];
    logic [TW-1:0] low_mem  [MAX_VERTICES];
    logic [VW-1:0] sv_mem   [MAX_VERTICES];
    logic [LW-1:0] sl_mem   [MAX_VERTICES];
    logic          vis_mem  [MAX_VERTICES];

    logic [VI:0]   idx_reg;
    logic [CW-1:0] cnt_reg;
    logic          drop_reg, art_reg, all_reg;
    logic [TW-1:0] time_reg;
    logic [DW-1:0] depth_reg;
    logic [DW-1:0] dm1;
    logic [1:0]    rootch_reg;
    logic [VW-1:0] a_reg, b_reg, u_reg, w_reg, p_reg;
    logic [LW-1:0] l_reg, ha_reg, nl_reg;
    logic [TW-1:0] lowu_reg, discw_reg, discp_reg, lowp_reg;
    logic          visw_reg;
    logic [VI:0]   paru_reg;
    logic [9:0]    n_eff;

    always_comb begin
        if (vertex_count == 9'd0) begin
            n_eff = 10'd1;
        end else if ({1'b0, vertex_count} > 10'(MAX_VERTICES)) begin
            n_eff = 10'(MAX_VERTICES);
        end else begin
            n_eff = {1'b0, vertex_count};
        end
    end

    // index of the stack top
    assign dm1 = depth_reg - 1'b1;

    assign stat.done = (st_reg == S_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= S_CLR;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            drop_reg     <= 1'b0;
            art_reg      <= 1'b0;
        end else begin
            unique case (st_reg)
                S_IDLE: begin
                    a_reg <= VW'(item.edge_a);
                    b_reg <= VW'(item.edge_b);
                    idx_reg <= '0;
                    if (cmd.start_clear) begin
                        st_reg <= S_CLR;
                    end else if (cmd.start_add) begin
                        if ({2'b0, item.edge_a} >= n_eff || {2'b0, item.edge_b} >= n_eff
                            || 32'(cnt_reg) + 32'd2 > 32'(HALF)) begin
                            drop_reg <= 1'b1;
                            st_reg <= S_DONE;
                        end else begin
                            st_reg <= S_ADD1;
                        end
                    end else if (cmd.start_check) begin
                        st_reg <= S_INIT;
                    end
                end
                S_CLR: begin
                    head_mem[idx_reg[VI-1:0]] <= LNONE;
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (VI+1)'(MAX_VERTICES - 1)) begin
                        cnt_reg  <= '0;
                        drop_reg <= 1'b0;
                        st_reg <= S_DONE;
                    end
                end
                S_ADD1: begin
                    ha_reg <= head_mem[a_reg[VI-1:0]];
                    st_reg <= S_ADD2;
                end
                S_ADD2: begin
                    // first half edge, then second in S_RD
                    tgt_mem[cnt_reg[HI-1:0]]  <= b_reg;
                    next_mem[cnt_reg[HI-1:0]] <= ha_reg;
                    head_mem[a_reg[VI-1:0]]   <= LW'(cnt_reg);
                    cnt_reg <= cnt_reg + 1'b1;
                    st_reg <= S_RD;
                    idx_reg[0] <= 1'b1;
                end
                S_RD: begin
                    if (idx_reg[0]) begin
                        ha_reg <= head_mem[b_reg[VI-1:0]];
                        idx_reg[0] <= 1'b0;
                    end else begin
                        tgt_mem[cnt_reg[HI-1:0]]  <= a_reg;
                        next_mem[cnt_reg[HI-1:0]] <= ha_reg;
                        head_mem[b_reg[VI-1:0]]   <= LW'(cnt_reg);
                        cnt_reg <= cnt_reg + 1'b1;
                        st_reg <= S_DONE;
                    end
                end
                S_INIT: begin
                    vis_mem[idx_reg[VI-1:0]] <= 1'b0;
                    par_mem[idx_reg[VI-1:0]] <= {1'b1, {VI{1'b0}}};
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (VI+1)'(MAX_VERTICES - 1)) begin
                        time_reg <= '0;
                        art_reg <= 1'b0;
                        rootch_reg <= '0;
                        depth_reg <= '0;
                        w_reg <= '0;
                        ha_reg <= head_mem[0];
                        all_reg <= 1'b1;
                        st_reg <= S_DISC;
                    end
                end
                S_DISC: begin
                    // push w, its list head already fetched
                    vis_mem[w_reg[VI-1:0]]  <= 1'b1;
                    disc_mem[w_reg[VI-1:0]] <= time_reg;
                    low_mem[w_reg[VI-1:0]]  <= time_reg;
                    time_reg <= time_reg + 1'b1;
                    sv_mem[depth_reg[VI-1:0]] <= w_reg;
                    sl_mem[depth_reg[VI-1:0]] <= ha_reg;
                    depth_reg <= depth_reg + 1'b1;
                    st_reg <= S_TOP;
                end
                S_TOP: begin
                    if (depth_reg == '0) begin
                        idx_reg <= '0;
                        st_reg <= S_SCAN;
                    end else begin
                        u_reg <= sv_mem[dm1[VI-1:0]];
                        l_reg <= sl_mem[dm1[VI-1:0]];
                        st_reg <= S_LINK;
                    end
                end
                S_LINK: begin
                    lowu_reg <= low_mem[u_reg[VI-1:0]];
                    paru_reg <= par_mem[u_reg[VI-1:0]];
                    if (l_reg == LNONE || 32'(l_reg) >= 32'(HALF)) begin
                        depth_reg <= depth_reg - 1'b1;
                        st_reg <= S_POP;
                    end else begin
                        nl_reg <= next_mem[l_reg[LW-2:0]];
                        w_reg <= tgt_mem[l_reg[LW-2:0]];
                        st_reg <= S_TGT;
                    end
                end
                S_TGT: begin
                    sl_mem[dm1[VI-1:0]] <= nl_reg;
                    if ({{(10-VW){1'b0}}, w_reg} >= n_eff) begin
                        st_reg <= S_TOP;
                    end else begin
                        visw_reg  <= vis_mem[w_reg[VI-1:0]];
                        discw_reg <= disc_mem[w_reg[VI-1:0]];
                        st_reg <= S_BACK;
                    end
                end
                S_BACK: begin
                    if (!visw_reg) begin
                        par_mem[w_reg[VI-1:0]] <= {1'b0, u_reg[VI-1:0]};
                        ha_reg <= head_mem[w_reg[VI-1:0]];
                        if (32'(depth_reg) < MAX_VERTICES) st_reg <= S_DISC;
                        else st_reg <= S_TOP;
                    end else begin
                        if ({1'b0, w_reg[VI-1:0]} != paru_reg && discw_reg < lowu_reg) begin
                            low_mem[u_reg[VI-1:0]] <= discw_reg;
                        end
                        st_reg <= S_TOP;
                    end
                end
                S_POP: begin
                    if (depth_reg == '0) begin
                        idx_reg <= '0;
                        st_reg <= S_SCAN;
                    end else begin
                        p_reg     <= sv_mem[dm1[VI-1:0]];
                        st_reg    <= S_POP2;
                        idx_reg[0] <= 1'b1;
                    end
                end
                S_POP2: begin
                    if (idx_reg[0]) begin
                        lowp_reg  <= low_mem[p_reg[VI-1:0]];
                        discp_reg <= disc_mem[p_reg[VI-1:0]];
                        idx_reg[0] <= 1'b0;
                    end else begin
                        if (lowu_reg < lowp_reg) low_mem[p_reg[VI-1:0]] <= lowu_reg;
                        if (depth_reg == DW'(1)) begin
                            if (rootch_reg != 2'd2) rootch_reg <= rootch_reg + 1'b1;
                        end else if (discp_reg <= lowu_reg) begin
                            art_reg <= 1'b1;
                        end
                        st_reg <= S_TOP;
                    end
                end
                S_SCAN: begin
                    if ({1'b0, idx_reg} < n_eff) begin
                        if (!vis_mem[idx_reg[VI-1:0]]) all_reg <= 1'b0;
                        idx_reg <= idx_reg + 1'b1;
                    end else begin
                        if (rootch_reg == 2'd2) art_reg <= 1'b1;
                        st_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign result.has_articulation = art_reg;
    assign result.all_reached      = all_reg;
    assign result.biconnected      = all_reg && !art_reg;
    assign result.edges_dropped    = drop_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_ADD2) |-> (32'(cnt_reg) + 32'd2 <= 32'(HALF)))
        else $error("half edge store overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_LINK) |-> (depth_reg != '0))
        else $error("link read on empty stack");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_DISC) |-> (32'(depth_reg) < MAX_VERTICES))
        else $error("search stack overflow");

endmodule

[hdl/gbc_ctrl.sv]
module gbc_ctrl import gbc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  gbc_in_t   in_item,
    output logic      out_valid,
    input  logic      out_ready,
    input  gbc_stat_t stat,
    output gbc_cmd_t  cmd,
    output logic      idle
);

    localparam logic [1:0] C_WAIT = 2'd0;
    localparam logic [1:0] C_BUSY = 2'd1;
    localparam logic [1:0] C_OUT  = 2'd2;
    localparam logic [1:0] C_BOOT = 2'd3;

    logic [1:0] st_reg;
    logic       chk_reg;

    assign in_ready  = (st_reg == C_WAIT);
    assign out_valid = (st_reg == C_OUT);
    assign idle      = (st_reg == C_WAIT);

    always_comb begin
        cmd = '0;
        if (in_valid && in_ready) begin
            cmd.start_add   = (in_item.kind == KIND_ADD);
            cmd.start_check = (in_item.kind == KIND_CHECK);
            cmd.start_clear = (in_item.kind == KIND_CLEAR);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= C_BOOT;
            chk_reg <= 1'b0;
        end else begin
            unique case (st_reg)
                C_BOOT: if (stat.done) st_reg <= C_WAIT;
                C_WAIT: begin
                    if (in_valid && (cmd.start_add || cmd.start_check || cmd.start_clear)) begin
                        chk_reg <= cmd.start_check;
                        st_reg  <= C_BUSY;
                    end
                end
                C_BUSY: if (stat.done) st_reg <= chk_reg ? C_OUT : C_WAIT;
                C_OUT:  if (out_ready) st_reg <= C_WAIT;
                default: st_reg <= C_WAIT;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> chk_reg)
        else $error("result without check");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid))
        else $error("accept during result");

endmodule
